// ===== design/memory_aware_admission_scheduler_unit_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; the using module must have i_clk and i_rst_n.
`ifndef MEMORY_AWARE_ADMISSION_SCHEDULER_UNIT_DEFINES_SVH
`define MEMORY_AWARE_ADMISSION_SCHEDULER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MAAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MAAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MAAU_ASSERT_IMP(lbl, ante, cons, msg)
`define MAAU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/maau_pkg.sv =====
// Shared constants, codes and types of the admission scheduler.
// Used by every module of the block; depends on nothing.
package maau_pkg;

    localparam int MaxClients = 16;
    localparam int ClientW    = 4;
    localparam int QAw        = $clog2(MaxClients);
    localparam int CountW     = $clog2(MaxClients + 1);
    localparam int MemW       = 48;
    localparam int PctW       = 7;
    localparam int DivW       = MemW + PctW;
    localparam int NoteCap    = 3 * MaxClients;
    localparam int NoteAw     = $clog2(NoteCap);
    localparam int NoteCntW   = $clog2(NoteCap + 1);
    localparam int GuardMax   = 4 * MaxClients + 4;
    localparam int GuardW     = $clog2(GuardMax + 1);

    localparam logic [PctW-1:0] Pct        = 7'd100;
    localparam logic [MemW-1:0] TotalReset = 48'd17179869184;
    localparam logic [PctW-1:0] ResReset   = 7'd10;

    // Event opcodes.
    localparam logic [1:0] OpRequest = 2'd0;
    localparam logic [1:0] OpRelease = 2'd1;
    localparam logic [1:0] OpUpdate  = 2'd2;
    localparam logic [1:0] OpDisconn = 2'd3;

    // Notice codes.
    localparam logic [1:0] NtGrant  = 2'd0;
    localparam logic [1:0] NtWait   = 2'd1;
    localparam logic [1:0] NtAvail  = 2'd2;
    localparam logic [1:0] NtStatus = 2'd3;

    // Scheduling modes.
    localparam logic [1:0] ModeAuto   = 2'd0;
    localparam logic [1:0] ModeSerial = 2'd1;
    localparam logic [1:0] ModeConc   = 2'd2;

    // Register indexes.
    localparam logic [1:0] CfgMode    = 2'd0;
    localparam logic [1:0] CfgTotal   = 2'd1;
    localparam logic [1:0] CfgReserve = 2'd2;

    // Queue operations.
    localparam logic [1:0] QNop       = 2'd0;
    localparam logic [1:0] QPushBack  = 2'd1;
    localparam logic [1:0] QPushFront = 2'd2;
    localparam logic [1:0] QTake      = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ClientW-1:0] client;
        logic [MemW-1:0]   memory_amount;
    } t_in;

    typedef struct packed {
        logic [ClientW-1:0] target_client;
        logic [1:0]        notice;
        logic [MemW-1:0]   memory_in_use;
        logic              device_busy;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [ClientW-1:0] target;
        logic [1:0]        kind;
    } t_note;

    typedef struct packed {
        logic [1:0]        op;
        logic [QAw-1:0]    idx;
        logic [ClientW-1:0] val;
    } t_q_cmd;

    typedef struct packed {
        logic [CountW-1:0]  count;
        logic [ClientW-1:0] head;
        logic [ClientW-1:0] rd_data;
        logic               found;
        logic [QAw-1:0]     found_idx;
    } t_q_stat;

endpackage

// ===== design/memory_aware_admission_scheduler_unit.sv =====
// Channel    | Direction | Handshake                   | Payload
// in         | input     | i_in_valid / o_in_ready     | i_in_data (maau_pkg::t_in)
// out        | output    | o_out_valid / i_out_ready   | o_out_data (maau_pkg::t_out)
// cfg        | input     | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// An item first forms the scaled admission limit and is dispatched, then walks
// the schedule one queue step at a time (wait queue scans, grants, moves), then
// closes; each notice is read, loaded and held until taken, and so is the
// final status.
// o_in_ready is high only while idle. Synchronous active-low reset clears all queues,
// flags and the memory sum.
// Depends on maau_pkg, maau_alu, maau_div, maau_queue and the defines header.
`include "memory_aware_admission_scheduler_unit_defines.svh"

module memory_aware_admission_scheduler_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  maau_pkg::t_in             i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output maau_pkg::t_out            o_out_data,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [maau_pkg::MemW-1:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIV   = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_UPD1  = 5'd3;
    localparam logic [4:0] S_UPD2  = 5'd4;
    localparam logic [4:0] S_REM1  = 5'd5;
    localparam logic [4:0] S_REM2  = 5'd6;
    localparam logic [4:0] S_REM3  = 5'd7;
    localparam logic [4:0] S_REM4  = 5'd8;
    localparam logic [4:0] S_SP    = 5'd9;
    localparam logic [4:0] S_CW    = 5'd10;
    localparam logic [4:0] S_DONE  = 5'd11;
    localparam logic [4:0] S_ORD   = 5'd12;
    localparam logic [4:0] S_OLD   = 5'd13;
    localparam logic [4:0] S_OWAIT = 5'd14;
    localparam logic [4:0] S_STLD  = 5'd15;
    localparam logic [4:0] S_STWT  = 5'd16;

    // Configuration.
    logic [1:0]                r_mode;
    logic [maau_pkg::MemW-1:0] r_total;
    logic [maau_pkg::PctW-1:0] r_res;

    // Event and scheduler state.
    logic [4:0]                    r_state;
    logic [1:0]                    r_op;
    logic [maau_pkg::ClientW-1:0]  r_c;
    logic [maau_pkg::MemW-1:0]     r_amt;
    logic [maau_pkg::DivW-1:0]     r_limit;
    logic [maau_pkg::MemW-1:0]     r_mem [maau_pkg::MaxClients];
    logic [maau_pkg::MaxClients-1:0] r_run;
    logic [maau_pkg::MemW-1:0]     r_sum;
    logic                          r_busy;
    logic [maau_pkg::CountW-1:0]   r_scan;
    logic [maau_pkg::GuardW-1:0]   r_guard;
    logic                          r_cw_done;
    logic                          r_cw_ret;
    logic                          r_sp_rem;
    logic [maau_pkg::NoteCntW-1:0] r_ncnt;
    logic [maau_pkg::NoteCntW-1:0] r_ridx;
    maau_pkg::t_note               r_note [maau_pkg::NoteCap];
    maau_pkg::t_note               r_note_rd;
    logic                          r_ov;
    maau_pkg::t_out                r_out;

    logic                          w_div_done;
    logic [maau_pkg::DivW-1:0]     w_div_limit;
    logic [maau_pkg::ClientW-1:0]  w_cur;
    logic [maau_pkg::MemW-1:0]     w_mem_rd;
    logic [maau_pkg::MemW-1:0]     w_b;
    logic [maau_pkg::MemW-1:0]     w_sat;
    logic [maau_pkg::MemW-1:0]     w_diff;
    logic                          w_fits;
    logic                          w_ge;
    logic                          w_can;
    logic                          w_newreq;
    logic                          w_emit;
    logic [1:0]                    w_kind;
    logic                          w_sp_proc;
    logic                          w_cw_hit;
    maau_pkg::t_q_cmd              w_pcmd;
    maau_pkg::t_q_cmd              w_wcmd;
    maau_pkg::t_q_stat             w_pstat;
    maau_pkg::t_q_stat             w_wstat;

    maau_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_in_valid && o_in_ready),
        .i_total   (r_total),
        .i_reserve (r_res),
        .o_done    (w_div_done),
        .o_limit   (w_div_limit)
    );

    maau_queue u_pend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_pcmd),
        .i_find  (r_c),
        .o_stat  (w_pstat)
    );

    maau_queue u_wait (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_wcmd),
        .i_find  (r_c),
        .o_stat  (w_wstat)
    );

    // Client under test this cycle.
    always_comb begin
        unique case (r_state)
            S_CW:    w_cur = w_wstat.rd_data;
            S_SP:    w_cur = w_pstat.head;
            default: w_cur = r_c;
        endcase
    end

    assign w_mem_rd = r_mem[w_cur];
    assign w_b      = (r_state == S_UPD2) ? r_amt : w_mem_rd;

    maau_alu u_alu (
        .i_a     (r_sum),
        .i_b     (w_b),
        .i_limit (r_limit),
        .o_sat   (w_sat),
        .o_fits  (w_fits),
        .o_diff  (w_diff),
        .o_ge    (w_ge)
    );

    // Admission check.
    always_comb begin
        if (r_mode == maau_pkg::ModeSerial)          w_can = !r_busy;
        else if (r_sum == '0)                        w_can = 1'b1;
        else if (r_mode == maau_pkg::ModeConc)       w_can = w_fits;
        else                                         w_can = w_fits || !r_busy;
    end

    assign w_newreq  = !r_run[r_c] && !w_pstat.found && !w_wstat.found;
    assign w_sp_proc = (r_guard < maau_pkg::GuardW'(maau_pkg::GuardMax))
                       && (w_pstat.count != '0);
    assign w_cw_hit  = (r_scan < w_wstat.count) && w_can;

    // Queue commands and notices for this cycle.
    always_comb begin
        w_pcmd = '{op: maau_pkg::QNop, idx: '0, val: w_cur};
        w_wcmd = '{op: maau_pkg::QNop, idx: '0, val: w_cur};
        w_emit = 1'b0;
        w_kind = maau_pkg::NtGrant;
        unique case (r_state)
            S_DISP: begin
                if (r_op == maau_pkg::OpRequest && w_newreq)
                    w_pcmd.op = maau_pkg::QPushBack;
            end
            S_CW: begin
                w_wcmd.idx = r_scan[maau_pkg::QAw-1:0];
                if (w_cw_hit) begin
                    w_wcmd.op = maau_pkg::QTake;
                    w_pcmd.op = maau_pkg::QPushFront;
                    w_emit    = 1'b1;
                    w_kind    = maau_pkg::NtAvail;
                end
            end
            S_SP: begin
                if (w_sp_proc) begin
                    w_pcmd.op = maau_pkg::QTake;
                    w_emit    = 1'b1;
                    if (!w_can) begin
                        w_wcmd.op = maau_pkg::QPushBack;
                        w_kind    = maau_pkg::NtWait;
                    end
                end
            end
            S_REM3: begin
                w_pcmd.idx = w_pstat.found_idx;
                w_wcmd.idx = w_wstat.found_idx;
                if (w_pstat.found) w_pcmd.op = maau_pkg::QTake;
                if (w_wstat.found) w_wcmd.op = maau_pkg::QTake;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= maau_pkg::ModeAuto;
            r_total <= maau_pkg::TotalReset;
            r_res   <= maau_pkg::ResReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                maau_pkg::CfgMode:    r_mode  <= i_cfg_data[1:0];
                maau_pkg::CfgTotal:   r_total <= i_cfg_data;
                maau_pkg::CfgReserve: r_res   <= i_cfg_data[maau_pkg::PctW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Notice buffer.
    always_ff @(posedge i_clk) begin
        if (w_emit && (r_ncnt < maau_pkg::NoteCntW'(maau_pkg::NoteCap)))
            r_note[r_ncnt[maau_pkg::NoteAw-1:0]] <= '{target: w_cur, kind: w_kind};
        r_note_rd <= r_note[r_ridx[maau_pkg::NoteAw-1:0]];
    end

    // Event payload and output register contents.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_op  <= i_in_data.opcode;
            r_c   <= i_in_data.client;
            r_amt <= i_in_data.memory_amount;
        end
        if (w_div_done) r_limit <= w_div_limit;
        if (r_state == S_OLD)
            r_out <= '{target_client: r_note_rd.target, notice: r_note_rd.kind,
                       memory_in_use: r_sum, device_busy: r_busy, last: 1'b0};
        else if (r_state == S_STLD)
            r_out <= '{target_client: r_c, notice: maau_pkg::NtStatus,
                       memory_in_use: r_sum, device_busy: r_busy, last: 1'b1};
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= '0;
            r_sum     <= '0;
            r_busy    <= 1'b0;
            r_scan    <= '0;
            r_guard   <= '0;
            r_cw_done <= 1'b0;
            r_cw_ret  <= 1'b0;
            r_sp_rem  <= 1'b0;
            r_ncnt    <= '0;
            r_ridx    <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < maau_pkg::MaxClients; i++) r_mem[i] <= '0;
        end else begin
            if (w_emit && (r_ncnt < maau_pkg::NoteCntW'(maau_pkg::NoteCap)))
                r_ncnt <= r_ncnt + 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ncnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) r_state <= S_DISP;
                end
                S_DISP: begin
                    r_guard   <= '0;
                    r_cw_done <= 1'b0;
                    r_sp_rem  <= 1'b0;
                    unique case (r_op)
                        maau_pkg::OpRequest: begin
                            if (w_newreq && (r_mode != maau_pkg::ModeSerial || !r_busy))
                                r_state <= S_SP;
                            else
                                r_state <= S_DONE;
                        end
                        maau_pkg::OpUpdate: r_state <= S_UPD1;
                        default:            r_state <= S_REM1;
                    endcase
                end
                S_UPD1: begin
                    r_mem[r_c] <= r_amt;
                    if (r_run[r_c]) begin
                        if (w_ge) r_sum <= w_diff;
                        r_state <= S_UPD2;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_UPD2: begin
                    r_sum   <= w_sat;
                    r_state <= S_DONE;
                end
                S_REM1: begin
                    if (r_run[r_c]) begin
                        r_sum        <= w_ge ? w_diff : '0;
                        r_run[r_c]   <= 1'b0;
                    end
                    r_state <= S_REM2;
                end
                S_REM2: begin
                    if (r_run == '0) begin
                        r_busy   <= 1'b0;
                        r_scan   <= '0;
                        r_guard  <= '0;
                        r_cw_ret <= 1'b0;
                        r_sp_rem <= 1'b1;
                        r_state  <= S_CW;
                    end else begin
                        r_state <= S_REM3;
                    end
                end
                S_REM3: begin
                    if (r_op == maau_pkg::OpDisconn) r_mem[r_c] <= '0;
                    r_state <= S_REM4;
                end
                S_REM4: begin
                    r_guard   <= '0;
                    r_cw_done <= 1'b0;
                    r_sp_rem  <= 1'b0;
                    r_state   <= r_busy ? S_DONE : S_SP;
                end
                S_SP: begin
                    if (w_sp_proc) begin
                        r_guard   <= r_guard + 1'b1;
                        r_cw_done <= 1'b0;
                        if (w_can) begin
                            r_run[w_cur] <= 1'b1;
                            r_busy       <= 1'b1;
                            r_sum        <= w_sat;
                            if (r_mode == maau_pkg::ModeSerial)
                                r_state <= r_sp_rem ? S_REM3 : S_DONE;
                        end
                    end else if (w_pstat.count == '0 && !r_cw_done
                                 && r_guard < maau_pkg::GuardW'(maau_pkg::GuardMax)) begin
                        r_scan   <= '0;
                        r_cw_ret <= 1'b1;
                        r_state  <= S_CW;
                    end else begin
                        r_state <= r_sp_rem ? S_REM3 : S_DONE;
                    end
                end
                S_CW: begin
                    if (r_scan >= w_wstat.count || w_cw_hit) begin
                        r_cw_done <= r_cw_ret;
                        r_state   <= S_SP;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_DONE: begin
                    r_ridx  <= '0;
                    r_state <= (r_ncnt == '0) ? S_STLD : S_ORD;
                end
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    r_ov    <= 1'b1;
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (i_out_ready) begin
                        r_ov    <= 1'b0;
                        r_ridx  <= r_ridx + 1'b1;
                        r_state <= (r_ridx + 1'b1 == r_ncnt) ? S_STLD : S_ORD;
                    end
                end
                S_STLD: begin
                    r_ov    <= 1'b1;
                    r_state <= S_STWT;
                end
                S_STWT: begin
                    if (i_out_ready) begin
                        r_ov    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `MAAU_ASSERT_IMP(a_ready_only_idle, o_in_ready, !o_out_valid,
        "input ready while a result is shown")
    `MAAU_ASSERT_IMP(a_queue_total, 1'b1,
        ({1'b0, w_pstat.count} + {1'b0, w_wstat.count})
            <= (maau_pkg::CountW + 1)'(maau_pkg::MaxClients),
        "pending plus waiting exceeds client count")
    `MAAU_ASSERT_IMP(a_idle_none_running, !r_busy, r_run == '0,
        "client running while device not busy")
    `MAAU_ASSERT_NXT(a_status_ends_item, o_out_valid && i_out_ready && o_out_data.last,
        o_in_ready, "block not idle after final status")

endmodule

// ===== design/maau_alu.sv =====
// Shared memory arithmetic: saturating add, admission fit compare, subtract.
// Depends on maau_pkg.
module maau_alu (
    input  logic [maau_pkg::MemW-1:0] i_a,
    input  logic [maau_pkg::MemW-1:0] i_b,
    input  logic [maau_pkg::DivW-1:0] i_limit,
    output logic [maau_pkg::MemW-1:0] o_sat,
    output logic                      o_fits,
    output logic [maau_pkg::MemW-1:0] o_diff,
    output logic                      o_ge
);

    logic [maau_pkg::MemW:0] w_full;
    logic [maau_pkg::DivW:0] w_ext;
    logic [maau_pkg::DivW:0] w_scaled;

    // One adder feeds both the saturating sum and the fit check.
    assign w_full = {1'b0, i_a} + {1'b0, i_b};
    assign o_sat  = w_full[maau_pkg::MemW] ? {maau_pkg::MemW{1'b1}}
                                            : w_full[maau_pkg::MemW-1:0];

    // A hundred times the sum is compared with the limit scaled by a hundred,
    // which gives the same answer as comparing against the truncated quotient.
    assign w_ext    = (maau_pkg::DivW + 1)'(w_full);
    assign w_scaled = (w_ext << 6) + (w_ext << 5) + (w_ext << 2);
    assign o_fits   = w_scaled <= {1'b0, i_limit};
    assign o_ge     = i_a >= i_b;
    assign o_diff   = i_a - i_b;

endmodule

// ===== design/maau_div.sv =====
// Admission limit unit: registers total * (100 - reserve), the limit scaled by a hundred.
// Depends on maau_pkg.
module maau_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [maau_pkg::MemW-1:0] i_total,
    input  logic [maau_pkg::PctW-1:0] i_reserve,
    output logic                      o_done,
    output logic [maau_pkg::DivW-1:0] o_limit
);

    logic [maau_pkg::PctW-1:0] w_res;
    logic [maau_pkg::PctW-1:0] w_keep;
    logic [maau_pkg::DivW-1:0] w_prod;

    logic                      r_done;
    logic [maau_pkg::DivW-1:0] r_prod;

    // Clamp the reserve and form the scaled limit.
    assign w_res  = (i_reserve > maau_pkg::Pct) ? maau_pkg::Pct : i_reserve;
    assign w_keep = maau_pkg::Pct - w_res;
    assign w_prod = maau_pkg::DivW'(i_total) * maau_pkg::DivW'(w_keep);

    // Control: done is registered from start, so the product is ready in the cycle after start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) r_prod <= w_prod;
    end

    assign o_done  = r_done;
    assign o_limit = r_prod;

endmodule

// ===== design/maau_queue.sv =====
// Client FIFO with push back, push front, take at any place and lookup.
// Depends on maau_pkg.
module maau_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  maau_pkg::t_q_cmd             i_cmd,
    input  logic [maau_pkg::ClientW-1:0] i_find,
    output maau_pkg::t_q_stat            o_stat
);

    logic [maau_pkg::ClientW-1:0] r_q [maau_pkg::MaxClients];
    logic [maau_pkg::CountW-1:0]  r_count;
    logic                         w_found;
    logic [maau_pkg::QAw-1:0]     w_fidx;
    logic                         w_full;

    assign w_full = r_count == maau_pkg::CountW'(maau_pkg::MaxClients);

    // First valid entry that holds the looked-up client.
    always_comb begin
        w_found = 1'b0;
        w_fidx  = '0;
        for (int i = maau_pkg::MaxClients - 1; i >= 0; i--) begin
            if ((maau_pkg::CountW'(i) < r_count) && (r_q[i] == i_find)) begin
                w_found = 1'b1;
                w_fidx  = maau_pkg::QAw'(i);
            end
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            unique case (i_cmd.op)
                maau_pkg::QPushBack,
                maau_pkg::QPushFront: begin
                    if (!w_full) r_count <= r_count + 1'b1;
                end
                maau_pkg::QTake: begin
                    if ({1'b0, i_cmd.idx} < r_count) r_count <= r_count - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Entries shift in place.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            maau_pkg::QPushBack: begin
                if (!w_full) r_q[r_count[maau_pkg::QAw-1:0]] <= i_cmd.val;
            end
            maau_pkg::QPushFront: begin
                if (!w_full) begin
                    r_q[0] <= i_cmd.val;
                    for (int j = 1; j < maau_pkg::MaxClients; j++) r_q[j] <= r_q[j-1];
                end
            end
            maau_pkg::QTake: begin
                if ({1'b0, i_cmd.idx} < r_count) begin
                    for (int j = 0; j < maau_pkg::MaxClients - 1; j++) begin
                        if (maau_pkg::QAw'(j) >= i_cmd.idx) r_q[j] <= r_q[j+1];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.count     = r_count;
    assign o_stat.head      = r_q[0];
    assign o_stat.rd_data   = r_q[i_cmd.idx];
    assign o_stat.found     = w_found;
    assign o_stat.found_idx = w_fidx;

endmodule
